[hdl/mt_pkg.sv]
// ----------------------------------------------------------------------------
// MT19937 package
// Types and constants shared by the generator's front queue, back sequencer
// and top level.
// ----------------------------------------------------------------------------
package mt_pkg;

    localparam int STATE_WORDS = 624;
    localparam int IDX_W       = 10;
    localparam int MID_DIST    = 397;

    localparam logic [31:0] INIT_MUL = 32'd1812433253;
    localparam logic [31:0] MATRIX   = 32'h9908b0df;
    localparam logic [31:0] UPPER    = 32'h80000000;
    localparam logic [31:0] LOWER    = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C = 32'hefc60000;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic        is_draw;
        logic [31:0] seed;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic seeded;
    } back_status_t;

endpackage

[hdl/mersenne_twister_generator.sv]
// ----------------------------------------------------------------------------
// MT19937 pseudo-random word generator
// Seed transactions fill the 624-word state; draw transactions return one
// tempered word each, twisting the whole state when it has been used up.
// ----------------------------------------------------------------------------
// Channel | Signals                        | Handshake
// input   | kind, seed_value               | in_valid / in_stall
// output  | random_word                    | out_valid / out_stall
//
// A draw tempers its word into the output register in S_DRAW_OUT. A used-up
// state is first twisted in S_TW_PRIME and S_TW_WR, one twist step per cycle
// on the state memory ports, and then read in S_DRAW_RD. A seed writes word 0,
// then each further word in S_SEED_MUL and S_SEED_WR through the registered
// multiplier. After reset there is no clearing pass; draws before the first
// seed give zero. The two-entry command queue fills even while output stalls.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);

    logic                 cmd_valid;
    mt_pkg::cmd_t         cmd;
    logic                 cmd_pop;
    mt_pkg::back_status_t status;

    mt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .seed_value (seed_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    mt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid && !status.busy)
        else $error("Command taken from an empty queue or by a busy sequencer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !cmd.is_draw |=> status.busy && status.seeded && !$rose(out_valid))
        else $error("Seed transaction did not start seeding or produced a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.is_draw && !status.seeded |=> out_valid && random_word == 32'd0)
        else $error("Draw before any seed did not return zero.");

endmodule

[hdl/mt_front.sv]
// ----------------------------------------------------------------------------
// MT19937 front queue
// Accepts input transactions, classifies them as seed or draw commands and
// holds them in a two-entry queue until the back sequencer takes them.
// ----------------------------------------------------------------------------
module mt_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [31:0]        seed_value,
    output logic               cmd_valid,
    output mt_pkg::cmd_t       cmd,
    input  logic               cmd_pop
);

    mt_pkg::cmd_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         pop;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].is_draw <= (kind == mt_pkg::KIND_DRAW);
            entry_reg[wr_ptr_reg].seed    <= seed_value;
        end
    end

endmodule

[hdl/mt_back.sv]
// ----------------------------------------------------------------------------
// MT19937 back sequencer
// Owns the 624-word state memory and runs seeding, the twist and tempered
// draws, one command at a time, into a registered output stage.
// ----------------------------------------------------------------------------
module mt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  mt_pkg::cmd_t         cmd,
    output logic                 cmd_pop,
    output mt_pkg::back_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          random_word
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEED_MUL = 3'd1;
    localparam logic [2:0] S_SEED_WR  = 3'd2;
    localparam logic [2:0] S_TW_PRIME = 3'd3;
    localparam logic [2:0] S_TW_WR    = 3'd4;
    localparam logic [2:0] S_DRAW_RD  = 3'd5;
    localparam logic [2:0] S_DRAW_OUT = 3'd6;

    localparam logic [mt_pkg::IDX_W-1:0] LAST_IDX  = mt_pkg::IDX_W'(mt_pkg::STATE_WORDS - 1);
    localparam logic [mt_pkg::IDX_W-1:0] WORDS_IDX = mt_pkg::IDX_W'(mt_pkg::STATE_WORDS);
    localparam logic [mt_pkg::IDX_W-1:0] MID_IDX   = mt_pkg::IDX_W'(mt_pkg::MID_DIST);
    localparam logic [mt_pkg::IDX_W:0]   WORDS_EXT = (mt_pkg::IDX_W+1)'(mt_pkg::STATE_WORDS);

    logic [31:0] mem [mt_pkg::STATE_WORDS];

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [mt_pkg::IDX_W-1:0]  idx_reg;
    logic [mt_pkg::IDX_W-1:0]  idx_next;
    logic [mt_pkg::IDX_W-1:0]  pos_reg;
    logic [mt_pkg::IDX_W-1:0]  pos_next;
    logic                      seeded_reg;
    logic                      seeded_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [31:0]               out_word_reg;
    logic [31:0]               out_word_next;
    logic [31:0]               prev_reg;
    logic [31:0]               prev_next;
    logic [31:0]               prod_reg;
    logic [31:0]               prod_next;
    logic [31:0]               cur_reg;
    logic [31:0]               cur_next;
    logic [31:0]               rd_a_reg;
    logic [31:0]               rd_b_reg;

    logic                      mem_we;
    logic [mt_pkg::IDX_W-1:0]  mem_waddr;
    logic [31:0]               mem_wdata;
    logic [mt_pkg::IDX_W-1:0]  raddr_a;
    logic [mt_pkg::IDX_W-1:0]  raddr_b;
    logic                      out_free;
    logic                      pos_ok;
    logic [31:0]               twist_y;
    logic [31:0]               twist_w;
    logic [31:0]               seed_w;

    function automatic logic [mt_pkg::IDX_W-1:0] wrap_idx(input logic [mt_pkg::IDX_W:0] s);
        logic [mt_pkg::IDX_W:0] t;
        t = (s >= WORDS_EXT) ? (s - WORDS_EXT) : s;
        return t[mt_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        r = r ^ (r >> 11);
        r = r ^ ((r << 7) & mt_pkg::TEMPER_B);
        r = r ^ ((r << 15) & mt_pkg::TEMPER_C);
        r = r ^ (r >> 18);
        return r;
    endfunction

    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign status.busy   = (state_reg != S_IDLE);
    assign status.seeded = seeded_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign pos_ok   = (pos_reg < WORDS_IDX);
    assign twist_y  = (cur_reg & mt_pkg::UPPER) | (rd_a_reg & mt_pkg::LOWER);
    assign twist_w  = rd_b_reg ^ (twist_y >> 1) ^ (rd_a_reg[0] ? mt_pkg::MATRIX : 32'd0);
    assign seed_w   = prod_reg + {22'd0, idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        prev_next      = prev_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = seed_w;
        raddr_a        = '0;
        raddr_b        = '0;
        cmd_pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                raddr_a = pos_ok ? pos_reg : '0;
                if (cmd_valid && !cmd.is_draw)
                begin
                    cmd_pop     = 1'b1;
                    mem_we      = 1'b1;
                    mem_waddr   = '0;
                    mem_wdata   = cmd.seed;
                    prev_next   = cmd.seed;
                    idx_next    = mt_pkg::IDX_W'(1);
                    seeded_next = 1'b1;
                    pos_next    = WORDS_IDX;
                    state_next  = S_SEED_MUL;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (!seeded_reg)
                    begin
                        out_word_next  = 32'd0;
                        out_valid_next = 1'b1;
                    end
                    else if (pos_ok)
                    begin
                        state_next = S_DRAW_OUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_TW_PRIME;
                    end
                end
            end
            S_SEED_MUL:
            begin
                prod_next  = mt_pkg::INIT_MUL * (prev_reg ^ (prev_reg >> 30));
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = seed_w;
                prev_next = seed_w;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + mt_pkg::IDX_W'(1);
                    state_next = S_SEED_MUL;
                end
            end
            S_TW_PRIME:
            begin
                cur_next   = rd_a_reg;
                raddr_a    = mt_pkg::IDX_W'(1);
                raddr_b    = MID_IDX;
                state_next = S_TW_WR;
            end
            S_TW_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = twist_w;
                cur_next  = rd_a_reg;
                raddr_a   = wrap_idx({1'b0, idx_reg} + (mt_pkg::IDX_W+1)'(2));
                raddr_b   = wrap_idx({1'b0, idx_reg} + {1'b0, MID_IDX} + (mt_pkg::IDX_W+1)'(1));
                if (idx_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = S_DRAW_RD;
                end
                else
                begin
                    idx_next = idx_reg + mt_pkg::IDX_W'(1);
                end
            end
            S_DRAW_RD:
            begin
                raddr_a    = pos_reg;
                state_next = S_DRAW_OUT;
            end
            S_DRAW_OUT:
            begin
                out_word_next  = temper(rd_a_reg);
                out_valid_next = 1'b1;
                pos_next       = pos_reg + mt_pkg::IDX_W'(1);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pos_reg       <= WORDS_IDX;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        prev_reg     <= prev_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

endmodule

[tb/sv/mersenne_twister_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives seed and draw transactions with random gaps and output stalls and
// predicts every tempered word. A scoreboard keeps its own copy of the state
// array and read position and checks each output in order. The stimulus
// covers draws before any seed, seed extremes, back-to-back seeds, a long run
// of draws deep into one seeded state, a random mix of seeds and draws, and
// one long output hold-off.
// ----------------------------------------------------------------------------

class mt19937_scoreboard;

    bit [31:0]   words [mt_pkg::STATE_WORDS];
    int unsigned read_pos;
    bit [31:0]   expected_words [$];
    int          errors;
    int          seeds;
    int          draws;
    int          twists;
    int          checked;

    function new();
        foreach (words[i])
            words[i] = '0;
        read_pos = mt_pkg::STATE_WORDS;
        errors   = 0;
        seeds    = 0;
        draws    = 0;
        twists   = 0;
        checked  = 0;
    endfunction

    function void note_transaction(logic is_draw, logic [31:0] seed);
        bit [31:0] y;
        bit [31:0] r;
        bit [31:0] nxt;

        if (is_draw == mt_pkg::KIND_SEED)
        begin
            words[0] = seed;
            for (int unsigned i = 1; i < mt_pkg::STATE_WORDS; i++)
                words[i] = mt_pkg::INIT_MUL * (words[i - 1] ^ (words[i - 1] >> 30)) + i;
            read_pos = mt_pkg::STATE_WORDS;
            seeds++;
            return;
        end

        if (read_pos >= mt_pkg::STATE_WORDS)
        begin
            for (int i = 0; i < mt_pkg::STATE_WORDS; i++)
            begin
                nxt = words[(i + 1) % mt_pkg::STATE_WORDS];
                y = (words[i] & mt_pkg::UPPER) | (nxt & mt_pkg::LOWER);
                r = y >> 1;
                if (nxt[0])
                    r ^= mt_pkg::MATRIX;
                words[i] = words[(i + mt_pkg::MID_DIST) % mt_pkg::STATE_WORDS] ^ r;
            end
            read_pos = 0;
            twists++;
        end

        r = words[read_pos];
        read_pos++;
        r ^= r >> 11;
        r ^= (r << 7) & mt_pkg::TEMPER_B;
        r ^= (r << 15) & mt_pkg::TEMPER_C;
        r ^= r >> 18;
        expected_words.push_back(r);
        draws++;
    endfunction

    function void check_word(logic [31:0] actual);
        bit [31:0] want;

        if (expected_words.size() == 0)
        begin
            $error("random_word: unexpected transaction, expected none, actual %h", actual);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        checked++;
        if (actual !== want)
        begin
            $error("random_word mismatch: expected %h, actual %h", want, actual);
            errors++;
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

endclass

module mersenne_twister_generator_tb;

    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 1300;
    localparam int LONG_DRAWS  = 454;
    localparam int MIXED_ITEMS = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] seed_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] random_word;

    mt19937_scoreboard sb;
    int                send_calm = 0;
    int                recv_calm = 0;
    int                words_taken = 0;

    mersenne_twister_generator i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic send_item(input logic k, input logic [31:0] s);
        int gap;

        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid   <= 1'b0;
            kind       <= 1'($urandom_range(0, 1));
            seed_value <= $urandom();
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        seed_value <= s;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_word(random_word);
            if (in_valid && !in_stall)
                sb.note_transaction(kind, seed_value);
        end
    end

    initial
    begin
        int gap;

        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (words_taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else
                gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            words_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int n;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = mt_pkg::KIND_SEED;
        seed_value = '0;
        sb = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Draws from the untouched reset state must give zero.
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_DRAW, 32'hffff_ffff);
        send_item(mt_pkg::KIND_SEED, 32'h0000_0000);
        send_item(mt_pkg::KIND_DRAW, 32'hffff_ffff);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_SEED, 32'hffff_ffff);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_SEED, 32'd5489);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        // Back-to-back seeds: the second one overwrites the state of the first.
        send_item(mt_pkg::KIND_SEED, 32'h0000_0001);
        send_item(mt_pkg::KIND_SEED, 32'h8000_0000);
        send_item(mt_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(mt_pkg::KIND_SEED, 32'h7fff_ffff);
        send_item(mt_pkg::KIND_DRAW, 32'haaaa_5555);

        // A long run of draws walks deep into one seeded state.
        for (n = 0; n < LONG_DRAWS; n++)
            send_item(mt_pkg::KIND_DRAW, $urandom());

        for (n = 0; n < MIXED_ITEMS; n++)
            send_item(($urandom_range(0, 5) == 0) ? mt_pkg::KIND_SEED : mt_pkg::KIND_DRAW,
                      $urandom());
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d seed and %0d draw transactions with %0d state twists.",
                 sb.seeds, sb.draws, sb.twists);
        $display("Checked %0d words, including one output hold-off of %0d cycles.",
                 sb.checked, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/mt_pkg.sv
hdl/mt_front.sv
hdl/mt_back.sv
hdl/mersenne_twister_generator.sv
tb/sv/mersenne_twister_generator_tb.sv
